[src/dmbf_pkg.sv]
// ----------------------------------------------------------------------------
// Dot-matrix band formatter package
// Shared constants, types and byte tables of the band formatter.
// ----------------------------------------------------------------------------
package dmbf_pkg;

  localparam int LINE_WIDTH   = 960;
  localparam int MAX_HEIGHT   = 1024;
  localparam int STORE_DEPTH  = 3 * LINE_WIDTH;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int STORE_W      = 8;

  localparam int WIDTH_W      = 10;
  localparam int HEIGHT_W     = 11;
  localparam int NEEDLE_W     = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 11;

  // Segment plan of one pass: a long segment whose count avoids bit 7, then the rest.
  localparam int SEG0_HI      = LINE_WIDTH / 256;
  localparam int SEG0_LO      = 127;
  localparam int SEG0_LEN     = SEG0_HI * 256 + SEG0_LO;
  localparam int SEG1_LEN     = LINE_WIDTH - SEG0_LEN;
  localparam int SEG1_LO      = SEG1_LEN % 256;
  localparam int SEG1_HI      = SEG1_LEN / 256;

  localparam int HDR_LEN      = 5;
  localparam int DATA0        = HDR_LEN;
  localparam int HDR1         = DATA0 + SEG0_LEN;
  localparam int DATA1        = HDR1 + HDR_LEN;
  localparam int TRL          = DATA1 + SEG1_LEN;
  localparam int PASS_LEN     = TRL + 4;
  localparam int POS_W        = $clog2(PASS_LEN);
  localparam int PROLOGUE_LEN = 13;
  localparam int LAST_PASS    = 2;
  localparam int LAST_NEEDLE  = 11;
  localparam int QUEUE_DEPTH  = 3;

  localparam logic [7:0] ESC       = 8'h1B;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_J     = 8'h4A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] GFX_MODE  = 8'h01;
  localparam logic [7:0] FEED_PASS = 8'd2;
  localparam logic [7:0] FEED_BAND = 8'd20;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_MODE  = 2'd2;

  typedef enum logic [1:0] {
    PH_PROLOGUE,
    PH_ACCEPT,
    PH_BAND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    logic       flush;
    logic       rejected;
    logic       done;
  } result_t;

  typedef struct packed {
    result_t             res;
    logic                from_store;
    logic                do_write;
    logic [ADDR_W-1:0]   addr;
    logic [STORE_W-1:0]  mask;
  } access_t;

  function automatic logic [7:0] prologue_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hFF;
      4'd1:    b = 8'hFF;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h74;
      4'd4:    b = 8'h72;
      4'd5:    b = 8'h61;
      4'd6:    b = 8'h6E;
      4'd7:    b = 8'h73;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h0A;
      4'd10:   b = ESC;
      4'd11:   b = CHR_J;
      4'd12:   b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [STORE_W-1:0] needle_mask(input logic [NEEDLE_W-1:0] n);
    logic [STORE_W-1:0] m;
    case (n)
      4'd0, 4'd1, 4'd2:   m = 8'h01;
      4'd3, 4'd4, 4'd5:   m = 8'h04;
      4'd6, 4'd7, 4'd8:   m = 8'h10;
      4'd9, 4'd10, 4'd11: m = 8'h40;
      default:            m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] needle_base(input logic [NEEDLE_W-1:0] n);
    logic [ADDR_W-1:0] a;
    case (n)
      4'd2, 4'd5, 4'd8, 4'd11: a = '0;
      4'd1, 4'd4, 4'd7, 4'd10: a = ADDR_W'(LINE_WIDTH);
      default:                 a = ADDR_W'(2 * LINE_WIDTH);
    endcase
    return a;
  endfunction

  function automatic logic band_is_store(input logic [POS_W-1:0] pos);
    return ((pos >= POS_W'(DATA0)) && (pos < POS_W'(HDR1))) ||
           ((pos >= POS_W'(DATA1)) && (pos < POS_W'(TRL)));
  endfunction

  function automatic logic [7:0] header_byte(input logic [2:0] off, input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic [7:0] b;
    case (off)
      3'd0:    b = ESC;
      3'd1:    b = CHR_STAR;
      3'd2:    b = GFX_MODE;
      3'd3:    b = lo;
      3'd4:    b = hi;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] band_const_byte(input logic [POS_W-1:0] pos,
                                                 input logic [1:0] pass);
    logic [POS_W-1:0] off;
    logic [7:0]       b;
    b = 8'h00;
    if (pos < POS_W'(DATA0)) begin
      b = header_byte(pos[2:0], 8'(SEG0_LO), 8'(SEG0_HI));
    end else if ((pos >= POS_W'(HDR1)) && (pos < POS_W'(DATA1))) begin
      off = pos - POS_W'(HDR1);
      b = header_byte(off[2:0], 8'(SEG1_LO), 8'(SEG1_HI));
    end else if (pos >= POS_W'(TRL)) begin
      off = pos - POS_W'(TRL);
      case (off[1:0])
        2'd0:    b = ESC;
        2'd1:    b = CHR_J;
        2'd2:    b = (pass < 2'(LAST_PASS)) ? FEED_PASS : FEED_BAND;
        default: b = CHR_CR;
      endcase
    end
    return b;
  endfunction

endpackage

[src/dmbf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dmbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/dot_matrix_band_formatter.sv]
// ----------------------------------------------------------------------------
// Dot-matrix band formatter
// Turns a bitmap, pushed a pixel per beat bottom row first, into a stream of
// 12-needle graphics bands printed as three interleaved passes.
//
// The input channel (in_valid, in_stall) carries one command per beat: a
// pixel push or a pull of one printer byte. Every command yields exactly one
// beat on the output channel (out_valid, out_stall). One command is taken
// per cycle while in_stall is low; each is at most one read-modify-write of
// the line store RAM, whose one read and one write port set that rate.
// A three-entry result queue lets the block keep taking commands while the
// receiver stalls; in_stall rises once that queue would overflow. The
// configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle, as the block
// itself does not enforce this. After reset all 2880 store entries are cleared,
// with in_stall held high; configuration writes are taken meanwhile. The store
// is cleared byte by byte as a band is pulled out, so no later pass is needed.
// ----------------------------------------------------------------------------
module dot_matrix_band_formatter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic                               in_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last_of_band,
  output logic                               out_flush_pending,
  output logic                               out_rejected,
  output logic                               out_image_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dmbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = dmbf_pkg::ADDR_W;
  localparam int PW = dmbf_pkg::POS_W;
  localparam int WW = dmbf_pkg::WIDTH_W;
  localparam int HW = dmbf_pkg::HEIGHT_W;
  localparam int NW = dmbf_pkg::NEEDLE_W;
  localparam int DW = dmbf_pkg::STORE_W;

  dmbf_pkg::phase_t  phase_r, phase_nxt;
  logic [WW-1:0]     img_width_r;
  logic [HW-1:0]     img_height_r;
  logic              center_r;
  logic [NW-1:0]     needle_r, needle_nxt;
  logic [WW-1:0]     col_r, col_nxt;
  logic [HW-1:0]     row_r, row_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [1:0]        pass_r, pass_nxt;
  logic [AW-1:0]     band_addr_r, band_addr_nxt;
  logic              band_final_r, band_final_nxt;
  logic              extra_final_r, extra_final_nxt;

  logic              clr_active_r;
  logic [AW-1:0]     clr_addr_r;

  logic                  in_accept;
  dmbf_pkg::access_t     acc_nxt;
  dmbf_pkg::access_t     s1_r;
  logic                  s1_v_r;

  logic [WW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;
  logic [WW-1:0]     bias;
  logic [WW:0]       col_abs;
  logic [WW:0]       col_inc;
  logic [HW:0]       row_inc;
  logic              full_band;
  logic              end_img;

  logic [DW-1:0]     ram_rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic [DW-1:0]     cur_data;
  dmbf_pkg::result_t s1_res;

  logic              wl_v_r;
  logic [AW-1:0]     wl_addr_r;
  logic [DW-1:0]     wl_data_r;

  dmbf_pkg::result_t q_r [dmbf_pkg::QUEUE_DEPTH];
  logic [1:0]        q_rd_r, q_wr_r, q_cnt_r;
  logic              q_pop;
  dmbf_pkg::result_t q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = clr_active_r ||
                     (({1'b0, q_cnt_r} + {2'b00, s1_v_r}) >= 3'(dmbf_pkg::QUEUE_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (img_width_r == '0) begin
      eff_w = WW'(1);
    end else if (img_width_r > WW'(dmbf_pkg::LINE_WIDTH)) begin
      eff_w = WW'(dmbf_pkg::LINE_WIDTH);
    end else begin
      eff_w = img_width_r;
    end
    if (img_height_r == '0) begin
      eff_h = HW'(1);
    end else if (img_height_r > HW'(dmbf_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(dmbf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = img_height_r;
    end
    bias    = center_r ? ((WW'(dmbf_pkg::LINE_WIDTH) - eff_w) >> 1) : '0;
    col_abs = {1'b0, col_r} + {1'b0, bias};
    col_inc = {1'b0, col_r} + (WW + 1)'(1);
    row_inc = {1'b0, row_r} + (HW + 1)'(1);
  end

  always_comb begin
    phase_nxt       = phase_r;
    needle_nxt      = needle_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    pos_nxt         = pos_r;
    pass_nxt        = pass_r;
    band_addr_nxt   = band_addr_r;
    band_final_nxt  = band_final_r;
    extra_final_nxt = extra_final_r;
    acc_nxt         = '0;
    full_band       = 1'b0;
    end_img         = 1'b0;
    if (in_accept) begin
      if (in_func == dmbf_pkg::FUNC_PULL) begin
        case (phase_r)
          dmbf_pkg::PH_PROLOGUE: begin
            acc_nxt.res.data       = dmbf_pkg::prologue_byte(pos_r[3:0]);
            acc_nxt.res.data_valid = 1'b1;
            if (pos_r == PW'(dmbf_pkg::PROLOGUE_LEN - 1)) begin
              acc_nxt.res.last = 1'b1;
              pos_nxt          = '0;
              phase_nxt        = dmbf_pkg::PH_ACCEPT;
            end else begin
              pos_nxt = pos_r + PW'(1);
            end
          end
          dmbf_pkg::PH_BAND: begin
            acc_nxt.res.data_valid = 1'b1;
            if (dmbf_pkg::band_is_store(pos_r)) begin
              acc_nxt.from_store = 1'b1;
              acc_nxt.do_write   = 1'b1;
              acc_nxt.addr       = band_addr_r;
              band_addr_nxt      = band_addr_r + AW'(1);
            end else begin
              acc_nxt.res.data = dmbf_pkg::band_const_byte(pos_r, pass_r);
            end
            if (pos_r == PW'(dmbf_pkg::PASS_LEN - 1)) begin
              pos_nxt = '0;
              if (pass_r == 2'(dmbf_pkg::LAST_PASS)) begin
                acc_nxt.res.last = 1'b1;
                pass_nxt         = '0;
                band_addr_nxt    = '0;
                if (extra_final_r) begin
                  extra_final_nxt = 1'b0;
                  band_final_nxt  = 1'b1;
                end else if (band_final_r) begin
                  phase_nxt = dmbf_pkg::PH_DONE;
                end else begin
                  phase_nxt = dmbf_pkg::PH_ACCEPT;
                end
              end else begin
                pass_nxt = pass_r + 2'd1;
              end
            end else begin
              pos_nxt = pos_r + PW'(1);
            end
          end
          default: begin
          end
        endcase
      end else if (phase_r != dmbf_pkg::PH_ACCEPT) begin
        acc_nxt.res.rejected = 1'b1;
      end else begin
        if (!in_pixel && (col_abs < (WW + 1)'(dmbf_pkg::LINE_WIDTH))) begin
          acc_nxt.do_write = 1'b1;
          acc_nxt.addr     = dmbf_pkg::needle_base(needle_r) + AW'(col_abs);
          acc_nxt.mask     = dmbf_pkg::needle_mask(needle_r);
        end
        if (col_inc >= {1'b0, eff_w}) begin
          full_band  = (needle_r == '0);
          end_img    = (row_inc >= {1'b0, eff_h});
          col_nxt    = '0;
          row_nxt    = row_inc[HW-1:0];
          needle_nxt = full_band ? NW'(dmbf_pkg::LAST_NEEDLE) : (needle_r - NW'(1));
          if (full_band || end_img) begin
            phase_nxt       = dmbf_pkg::PH_BAND;
            pos_nxt         = '0;
            pass_nxt        = '0;
            band_addr_nxt   = '0;
            band_final_nxt  = end_img && !full_band;
            extra_final_nxt = end_img && full_band;
          end
        end else begin
          col_nxt = col_inc[WW-1:0];
        end
      end
      acc_nxt.res.flush = (phase_nxt == dmbf_pkg::PH_PROLOGUE) ||
                          (phase_nxt == dmbf_pkg::PH_BAND);
      acc_nxt.res.done  = (phase_nxt == dmbf_pkg::PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dmbf_pkg::PH_PROLOGUE;
      img_width_r   <= WW'(dmbf_pkg::LINE_WIDTH);
      img_height_r  <= HW'(dmbf_pkg::MAX_HEIGHT);
      center_r      <= 1'b0;
      needle_r      <= NW'(dmbf_pkg::LAST_NEEDLE);
      col_r         <= '0;
      row_r         <= '0;
      pos_r         <= '0;
      pass_r        <= '0;
      band_addr_r   <= '0;
      band_final_r  <= 1'b0;
      extra_final_r <= 1'b0;
      clr_active_r  <= 1'b1;
      clr_addr_r    <= '0;
      s1_v_r        <= 1'b0;
      wl_v_r        <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      needle_r      <= needle_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      pos_r         <= pos_nxt;
      pass_r        <= pass_nxt;
      band_addr_r   <= band_addr_nxt;
      band_final_r  <= band_final_nxt;
      extra_final_r <= extra_final_nxt;
      s1_v_r        <= in_accept;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dmbf_pkg::CFG_IMAGE_WIDTH:  img_width_r  <= cfg_data[WW-1:0];
          dmbf_pkg::CFG_IMAGE_HEIGHT: img_height_r <= cfg_data[HW-1:0];
          dmbf_pkg::CFG_CENTER_MODE:  center_r     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(dmbf_pkg::STORE_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (ram_we && !clr_active_r) begin
        wl_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= acc_nxt;
    end
    if (ram_we) begin
      wl_addr_r <= ram_waddr;
      wl_data_r <= ram_wdata;
    end
  end

  dmbf_ram #(
    .WIDTH (DW),
    .DEPTH (dmbf_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept && acc_nxt.do_write),
    .raddr (acc_nxt.addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_data = (wl_v_r && (wl_addr_r == s1_r.addr)) ? wl_data_r : ram_rdata;
    s1_res   = s1_r.res;
    if (s1_r.from_store) begin
      s1_res.data = cur_data;
    end
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_v_r && s1_r.do_write;
      ram_waddr = s1_r.addr;
      ram_wdata = s1_r.from_store ? '0 : (cur_data | s1_r.mask);
    end
  end

  assign q_pop  = (q_cnt_r != 2'd0) && !out_stall;
  assign q_head = q_r[q_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_rd_r  <= '0;
      q_wr_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s1_v_r) begin
        q_wr_r <= (q_wr_r == 2'(dmbf_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : (q_wr_r + 2'd1);
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == 2'(dmbf_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : (q_rd_r + 2'd1);
      end
      q_cnt_r <= q_cnt_r + {1'b0, s1_v_r} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      q_r[q_wr_r] <= s1_res;
    end
  end

  assign out_valid         = (q_cnt_r != 2'd0);
  assign out_byte          = q_head.data;
  assign out_byte_valid    = q_head.data_valid;
  assign out_last_of_band  = q_head.last;
  assign out_flush_pending = q_head.flush;
  assign out_rejected      = q_head.rejected;
  assign out_image_done    = q_head.done;

endmodule
